/* hw/rtl/tlv_stream_deframer_macros.svh */
`ifndef TLV_STREAM_DEFRAMER_MACROS_SVH
`define TLV_STREAM_DEFRAMER_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define TLVD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication into the next cycle
`define TLVD_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

/* hw/rtl/tlvd_pkg.sv */
package tlvd_pkg;

   localparam int unsigned LEN_W = 16;
   localparam int unsigned MAX_W = 17;

   localparam logic [MAX_W-1:0] HEADER_BYTES = 17'd3;
   localparam logic [MAX_W-1:0] MAX_RESET    = 17'd65538;

   localparam logic [1:0] STATUS_DATA  = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_DROP  = 2'd2;

   typedef enum logic [1:0] {
      HDR_TAG,
      HDR_LEN_HI,
      HDR_LEN_LO,
      VALUE_BYTES
   } tlvd_state_type;

   typedef struct packed {
      logic             valid;
      logic [1:0]       status;
      logic [7:0]       tag;
      logic [LEN_W-1:0] value_length;
      logic [7:0]       value_byte;
      logic             last;
   } tlvd_result_type;

endpackage

/* hw/rtl/tlvd_channels.sv */
interface tlvd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface tlvd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [7:0]  tag;
   logic [15:0] value_length;
   logic [7:0]  value_byte;
   logic        last;

   modport source (output valid, output status, output tag, output value_length,
                   output value_byte, output last, input ready);
   modport sink   (input valid, input status, input tag, input value_length,
                   input value_byte, input last, output ready);
endinterface

/* hw/rtl/tlvd_parser.sv */
module tlvd_parser import tlvd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_fire,
   input  logic [7:0]       in_byte,
   input  logic             cfg_we,
   input  logic [MAX_W-1:0] cfg_data,
   output tlvd_result_type  result
);

   tlvd_state_type   state_ff, state_in;
   logic [7:0]       tag_ff, tag_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic             drop_ff, drop_in;
   logic [MAX_W-1:0] max_ff;

   logic [LEN_W-1:0] new_len;
   logic [MAX_W-1:0] total;
   logic             oversize;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= HDR_TAG;
         tag_ff   <= '0;
         len_ff   <= '0;
         rem_ff   <= '0;
         drop_ff  <= 1'b0;
         max_ff   <= MAX_RESET;
      end else begin
         state_ff <= state_in;
         tag_ff   <= tag_in;
         len_ff   <= len_in;
         rem_ff   <= rem_in;
         drop_ff  <= drop_in;
         if (cfg_we) begin
            max_ff <= cfg_data;
         end
      end
   end

   assign new_len  = {len_ff[LEN_W-1:8], in_byte};
   assign total    = HEADER_BYTES + {1'b0, new_len};
   assign oversize = total > max_ff;

   always_comb begin
      state_in            = state_ff;
      tag_in              = tag_ff;
      len_in              = len_ff;
      rem_in              = rem_ff;
      drop_in             = drop_ff;
      result              = '0;
      result.tag          = tag_ff;
      result.value_length = len_ff;
      if (in_fire) begin
         case (state_ff)
            HDR_TAG: begin
               tag_in   = in_byte;
               state_in = HDR_LEN_HI;
            end
            HDR_LEN_HI: begin
               len_in   = {in_byte, 8'h00};
               state_in = HDR_LEN_LO;
            end
            HDR_LEN_LO: begin
               len_in              = new_len;
               result.value_length = new_len;
               if (new_len == '0) begin
                  state_in      = HDR_TAG;
                  drop_in       = 1'b0;
                  result.valid  = 1'b1;
                  result.status = oversize ? STATUS_DROP : STATUS_EMPTY;
                  result.last   = 1'b1;
               end else begin
                  rem_in   = new_len;
                  drop_in  = oversize;
                  state_in = VALUE_BYTES;
               end
            end
            VALUE_BYTES: begin
               rem_in = rem_ff - LEN_W'(1);
               if (rem_ff == {{(LEN_W-1){1'b0}}, 1'b1}) begin
                  state_in          = HDR_TAG;
                  drop_in           = 1'b0;
                  result.valid      = 1'b1;
                  result.status     = drop_ff ? STATUS_DROP : STATUS_DATA;
                  result.value_byte = drop_ff ? 8'h00 : in_byte;
                  result.last       = 1'b1;
               end else if (!drop_ff) begin
                  result.valid      = 1'b1;
                  result.status     = STATUS_DATA;
                  result.value_byte = in_byte;
               end
            end
            default: begin
               state_in = HDR_TAG;
            end
         endcase
      end
   end

endmodule

/* hw/rtl/tlvd_out_reg.sv */
module tlvd_out_reg import tlvd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  tlvd_result_type result,
   input  logic            out_ready,
   output logic            free,
   output tlvd_result_type held
);

   logic            valid_ff;
   tlvd_result_type data_ff;

   assign free = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= result.valid;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load && result.valid) begin
         data_ff <= result;
      end
   end

   always_comb begin
      held       = data_ff;
      held.valid = valid_ff;
   end

endmodule

/* hw/rtl/tlv_stream_deframer.sv */
// channel | dir | payload                                           | handshake
// req     | in  | data_byte[7:0]                                    | valid/ready
// rsp     | out | status[1:0] tag[7:0] value_length[15:0]           | valid/ready
//         |     | value_byte[7:0] last                              |
// csr     | in  | csr_wr_data[16:0] (max_message_bytes)             | csr_wr_en
//
// One word per cycle unless rsp stalls; a result shows in the cycle after its word.
// Header state and counters sit in the parser; one result register feeds rsp.
// req ready is low only while a result waits and rsp ready is low.
// Synchronous reset: expect a tag word, max_message_bytes = 65538.
module tlv_stream_deframer import tlvd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   tlvd_req_if.sink         req_chan,
   tlvd_rsp_if.source       rsp_chan,
   input  logic             csr_wr_en,
   input  logic [MAX_W-1:0] csr_wr_data
);

   logic            in_fire;
   logic            out_free;
   tlvd_result_type result;
   tlvd_result_type held;

   assign req_chan.ready = out_free;
   assign in_fire        = req_chan.valid && out_free;

   tlvd_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .in_fire  (in_fire),
      .in_byte  (req_chan.data_byte),
      .cfg_we   (csr_wr_en),
      .cfg_data (csr_wr_data),
      .result   (result)
   );

   tlvd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (in_fire),
      .result    (result),
      .out_ready (rsp_chan.ready),
      .free      (out_free),
      .held      (held)
   );

   assign rsp_chan.valid        = held.valid;
   assign rsp_chan.status       = held.status;
   assign rsp_chan.tag          = held.tag;
   assign rsp_chan.value_length = held.value_length;
   assign rsp_chan.value_byte   = held.value_byte;
   assign rsp_chan.last         = held.last;

endmodule

/* hw/rtl/tlvd_checker.sv */
`include "tlv_stream_deframer_macros.svh"

module tlvd_checker import tlvd_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_value_byte,
   input logic       rsp_last
);

   `TLVD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid,
                     "rsp word dropped while stalled")
   `TLVD_ASSERT(a_req_stall, clock, reset, (rsp_valid && !rsp_ready) |-> !req_ready,
                "req taken while rsp stalled")
   `TLVD_ASSERT(a_status_code, clock, reset,
                rsp_valid |-> (rsp_status == STATUS_DATA || rsp_status == STATUS_EMPTY
                               || rsp_status == STATUS_DROP),
                "bad status code")
   `TLVD_ASSERT(a_end_word, clock, reset,
                (rsp_valid && rsp_status != STATUS_DATA) |->
                   (rsp_last && rsp_value_byte == 8'h00),
                "end word not last or not zero")

endmodule

bind tlv_stream_deframer tlvd_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_status     (rsp_chan.status),
   .rsp_value_byte (rsp_chan.value_byte),
   .rsp_last       (rsp_chan.last)
);

/* tb/tlv_stream_deframer_tb.sv */
module tlv_stream_deframer_tb;
   import tlvd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned STALL_LIMIT   = 2000;
   localparam int unsigned RANDOM_WORDS  = 400;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned IDLE_PERCENT  = 34;

   class tlv_frame_scoreboard;
      tlvd_state_type   position;
      logic [7:0]       held_tag;
      logic [LEN_W-1:0] held_length;
      logic [LEN_W-1:0] remaining;
      logic             skipping;
      logic [MAX_W-1:0] max_bytes;
      tlvd_result_type  pending_results[$];
      int unsigned      errors;

      function new();
         position    = HDR_TAG;
         held_tag    = '0;
         held_length = '0;
         remaining   = '0;
         skipping    = 1'b0;
         max_bytes   = MAX_RESET;
         errors      = 0;
      endfunction

      function void set_max(logic [MAX_W-1:0] value);
         max_bytes = value;
      endfunction

      function void push_result(logic [1:0] status, logic [7:0] value_byte, logic last);
         tlvd_result_type r;
         r.valid        = 1'b1;
         r.status       = status;
         r.tag          = held_tag;
         r.value_length = held_length;
         r.value_byte   = value_byte;
         r.last         = last;
         pending_results.push_back(r);
      endfunction

      function void absorb_word(logic [7:0] b);
         case (position)
            HDR_TAG: begin
               held_tag = b;
               position = HDR_LEN_HI;
            end
            HDR_LEN_HI: begin
               held_length = {b, 8'h00};
               position    = HDR_LEN_LO;
            end
            HDR_LEN_LO: begin
               held_length[7:0] = b;
               skipping = (HEADER_BYTES + {1'b0, held_length}) > max_bytes;
               if (held_length == '0) begin
                  push_result(skipping ? STATUS_DROP : STATUS_EMPTY, 8'h00, 1'b1);
                  skipping = 1'b0;
                  position = HDR_TAG;
               end else begin
                  remaining = held_length;
                  position  = VALUE_BYTES;
               end
            end
            default: begin
               remaining = remaining - LEN_W'(1);
               if (remaining == '0) begin
                  position = HDR_TAG;
                  if (skipping) begin
                     skipping = 1'b0;
                     push_result(STATUS_DROP, 8'h00, 1'b1);
                  end else begin
                     push_result(STATUS_DATA, b, 1'b1);
                  end
               end else if (!skipping) begin
                  push_result(STATUS_DATA, b, 1'b0);
               end
            end
         endcase
      endfunction

      function void compare_field(string name, longint unsigned wanted, longint unsigned seen);
         if (wanted != seen) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, wanted, seen);
            errors++;
         end
      endfunction

      function void check_result(tlvd_result_type seen);
         tlvd_result_type wanted;
         if (pending_results.size() == 0) begin
            $error("result with nothing outstanding: status %0d tag 0x%0h length %0d",
                   seen.status, seen.tag, seen.value_length);
            errors++;
         end else begin
            wanted = pending_results.pop_front();
            compare_field("status", wanted.status, seen.status);
            compare_field("tag", wanted.tag, seen.tag);
            compare_field("value_length", wanted.value_length, seen.value_length);
            compare_field("value_byte", wanted.value_byte, seen.value_byte);
            compare_field("last", wanted.last, seen.last);
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_wr_en;
   logic [MAX_W-1:0] csr_wr_data;
   logic             no_idle = 1'b0;
   int unsigned      stall_cycles = 0;
   int unsigned      random_words = 0;

   tlvd_req_if req_chan();
   tlvd_rsp_if rsp_chan();

   tlv_frame_scoreboard frames = new();

   tlv_stream_deframer DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2ns clock = ~clock;

   always @(posedge clock) begin
      rsp_chan.ready <= !reset && (no_idle || $urandom_range(0, 99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            frames.check_result('{valid: 1'b1, status: rsp_chan.status, tag: rsp_chan.tag,
                                  value_length: rsp_chan.value_length,
                                  value_byte: rsp_chan.value_byte, last: rsp_chan.last});
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("tlv_stream_deframer test failed");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   task automatic send_word(input logic [7:0] b);
      while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_chan.valid     <= 1'b0;
         req_chan.data_byte <= 8'($urandom);
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      frames.absorb_word(b);
   endtask

   task automatic send_header(input logic [7:0] tag, input logic [LEN_W-1:0] length);
      send_word(tag);
      send_word(length[15:8]);
      send_word(length[7:0]);
   endtask

   task automatic send_message(input logic [7:0] tag, input logic [LEN_W-1:0] length);
      send_header(tag, length);
      for (int unsigned i = 0; i < length; i++) send_word(8'($urandom));
   endtask

   // hold off until every result is out and the parser has gone quiet
   task automatic write_max(input logic [MAX_W-1:0] value);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (frames.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      frames.set_max(value);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_random_message();
      logic [LEN_W-1:0] length;
      int unsigned      pick;
      pick = $urandom_range(0, 99);
      if (pick < 15)      length = '0;
      else if (pick < 70) length = LEN_W'($urandom_range(1, 12));
      else if (pick < 93) length = LEN_W'($urandom_range(13, 40));
      else                length = LEN_W'($urandom_range(41, 300));
      send_message(8'($urandom), length);
      random_words += 3 + length;
   endtask

   initial begin
      logic [MAX_W-1:0] phase_max[$];
      int unsigned      phase_target;
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= '0;
      req_chan.valid     <= 1'b0;
      req_chan.data_byte <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_header(8'h00, 16'd0);
      send_header(8'hFF, 16'd1);
      send_word(8'hFF);
      send_header(8'h5A, 16'd3);
      send_word(8'h00);
      send_word(8'h80);
      send_word(8'h7F);

      write_max(HEADER_BYTES);
      send_header(8'h11, 16'd0);
      send_header(8'h22, 16'd1);
      send_word(8'hAB);

      write_max('0);
      send_header(8'h33, 16'd0);
      send_header(8'hC3, 16'd2);
      send_word(8'h01);
      send_word(8'hFE);

      phase_max = '{'1, MAX_RESET, HEADER_BYTES, 17'd8, 17'd12, 17'd20,
                    MAX_W'($urandom_range(3, 45)), 17'd2, MAX_RESET - MAX_W'(1),
                    MAX_W'($urandom_range(3, 310)), 17'd4, MAX_W'($urandom)};
      foreach (phase_max[p]) begin
         write_max(phase_max[p]);
         no_idle      = (p == 4);
         phase_target = random_words + RANDOM_WORDS / phase_max.size();
         while (random_words < phase_target) send_random_message();
      end
      no_idle = 1'b0;

      // largest message that fits the limit, then one word over it
      write_max(17'd10);
      send_message(8'($urandom), 16'd7);
      send_message(8'($urandom), 16'd8);

      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (frames.pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (frames.errors == 0 && frames.pending_results.size() == 0) begin
         $display("tlv_stream_deframer test passed");
      end else begin
         $display("tlv_stream_deframer test failed");
      end
      $finish;
   end

endmodule
